/* rtl/scheme_token_scanner_top_assert.svh */
// assertion macros used by the scanner checker
`ifndef SCHEME_TOKEN_SCANNER_TOP_ASSERT_SVH
`define SCHEME_TOKEN_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define STS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scanner check failed");

// next-cycle implication, sampled on clk_i, quiet during reset
`define STS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

/* rtl/sts_pkg.sv */
// types, constants and helper functions of the scheme token scanner
package sts_pkg;

  localparam int LengthBits = 16;
  localparam int MaxResults = 4;
  localparam int QDepth     = 8;
  localparam int QPtrBits   = $clog2(QDepth);
  localparam int QCntBits   = $clog2(QDepth + 1);
  localparam int NumKw      = 5;

  localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

  // token kinds
  localparam logic [3:0] TokEnd     = 4'd0;
  localparam logic [3:0] TokOpen    = 4'd1;
  localparam logic [3:0] TokClose   = 4'd2;
  localparam logic [3:0] TokQuote   = 4'd3;
  localparam logic [3:0] TokPeriod  = 4'd4;
  localparam logic [3:0] TokString  = 4'd5;
  localparam logic [3:0] TokBool    = 4'd6;
  localparam logic [3:0] TokChar    = 4'd7;
  localparam logic [3:0] TokHash    = 4'd8;
  localparam logic [3:0] TokNumber  = 4'd9;
  localparam logic [3:0] TokSymbol  = 4'd10;
  localparam logic [3:0] TokKwFirst = 4'd11;

  // result kinds
  localparam logic RkRecord = 1'b0;
  localparam logic RkText   = 1'b1;

  // characters
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowT   = 8'h74;

  // keyword spellings, left aligned in 13 characters
  localparam logic [NumKw-1:0][103:0] KwText = {
    "syntax-rules ", "define-syntax", "if           ", "lambda       ", "define       "
  };
  localparam logic [NumKw-1:0][3:0] KwLen = {4'd12, 4'd13, 4'd2, 4'd6, 4'd6};

  typedef enum logic [6:0] {
    ModeIdle    = 7'b0000001,
    ModeComment = 7'b0000010,
    ModeString  = 7'b0000100,
    ModeNumber  = 7'b0001000,
    ModeSymbol  = 7'b0010000,
    ModeHash    = 7'b0100000,
    ModeHashBs  = 7'b1000000
  } sts_mode_e;

  typedef struct packed {
    logic                  result_kind;
    logic [3:0]            token_kind;
    logic [30:0]           token_value;
    logic [7:0]            text_char;
    logic [LengthBits-1:0] text_length;
    logic                  last_of_run;
  } sts_result_t;

  typedef struct packed {
    sts_result_t [MaxResults-1:0] res;
    logic [2:0]                   count;
  } sts_batch_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  function automatic logic is_ident(input logic [7:0] b);
    logic hit;
    hit = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) || is_digit(b);
    unique case (b)
      "!", "@", "#", "$", "%", "^", "&", "*",
      "_", "-", "=", "+", "/", "?", "<", ">": hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

  // drop candidates whose spelling differs at position p
  function automatic logic [NumKw-1:0] kw_update(input logic [NumKw-1:0] kw,
                                                 input logic [LengthBits-1:0] p,
                                                 input logic [7:0] b);
    logic [NumKw-1:0] nk;
    int idx;
    nk = kw;
    for (int k = 0; k < NumKw; k++) begin
      if (p < LengthBits'(KwLen[k])) begin
        idx = 8 * (12 - int'(p[3:0]));
        if (KwText[k][idx +: 8] != b) nk[k] = 1'b0;
      end else begin
        nk[k] = 1'b0;
      end
    end
    return nk;
  endfunction

  function automatic logic [3:0] symbol_kind(input logic [NumKw-1:0] kw,
                                             input logic [LengthBits-1:0] cnt);
    logic [3:0] kind;
    kind = TokSymbol;
    for (int k = 0; k < NumKw; k++) begin
      if (kw[k] && (cnt == LengthBits'(KwLen[k]))) kind = TokKwFirst + 4'(k);
    end
    return kind;
  endfunction

  function automatic sts_result_t mk_rec(input logic [3:0] kind, input logic [30:0] value,
                                         input logic [LengthBits-1:0] len);
    sts_result_t r;
    r.result_kind = RkRecord;
    r.token_kind  = kind;
    r.token_value = value;
    r.text_char   = 8'd0;
    r.text_length = len;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic sts_result_t mk_text(input logic [3:0] kind, input logic [7:0] ch);
    sts_result_t r;
    r.result_kind = RkText;
    r.token_kind  = kind;
    r.token_value = 31'd0;
    r.text_char   = ch;
    r.text_length = '0;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

/* rtl/sts_scanner.sv */
// scanner state and the per-byte token logic
module sts_scanner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  input  logic               fin_i,
  output sts_pkg::sts_batch_t batch_o
);

  sts_pkg::sts_mode_e                   mode_q, mode_d;
  logic [30:0]                          acc_q, acc_d;
  logic [sts_pkg::LengthBits-1:0]       cnt_q, cnt_d;
  logic [sts_pkg::NumKw-1:0]            kw_q, kw_d;
  logic                                 stop_q, stop_d;

  sts_pkg::sts_result_t [sts_pkg::MaxResults-1:0] res;
  logic [2:0]  n;
  logic        rescan;
  logic [34:0] acc_prod;
  logic [7:0]  digit;

  function automatic logic [sts_pkg::LengthBits-1:0] sat_inc(
      input logic [sts_pkg::LengthBits-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign digit    = byte_i - sts_pkg::ChZero;
  assign acc_prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {27'd0, digit};

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    kw_d   = kw_q;
    stop_d = stop_q;
    res    = '0;
    n      = 3'd0;
    rescan = 1'b0;

    if (stop_q) begin
      // ignore the rest of an ended text until its final byte
      if (fin_i) begin
        mode_d = sts_pkg::ModeIdle;
        acc_d  = '0;
        cnt_d  = '0;
        kw_d   = '1;
        stop_d = 1'b0;
      end
    end else begin
      unique case (mode_q)
        sts_pkg::ModeComment: begin
          if (byte_i == sts_pkg::ChLf) begin
            mode_d = sts_pkg::ModeIdle;
          end else if (byte_i == sts_pkg::ChNul) begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokEnd, '0, '0);
            n = n + 3'd1;
            stop_d = 1'b1;
            mode_d = sts_pkg::ModeIdle;
          end
        end
        sts_pkg::ModeString: begin
          if (byte_i == sts_pkg::ChDquote) begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokString, '0, cnt_q);
            n = n + 3'd1;
            mode_d = sts_pkg::ModeIdle;
          end else if (byte_i == sts_pkg::ChNul) begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokString, '0, cnt_q);
            n = n + 3'd1;
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokEnd, '0, '0);
            n = n + 3'd1;
            stop_d = 1'b1;
            mode_d = sts_pkg::ModeIdle;
          end else begin
            res[n[1:0]] = sts_pkg::mk_text(sts_pkg::TokString, byte_i);
            n = n + 3'd1;
            cnt_d = sat_inc(cnt_q);
          end
        end
        sts_pkg::ModeNumber: begin
          if (sts_pkg::is_digit(byte_i)) begin
            acc_d = (acc_prod > {4'd0, sts_pkg::NumMax}) ? sts_pkg::NumMax : acc_prod[30:0];
          end else begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokNumber, acc_q, '0);
            n = n + 3'd1;
            rescan = 1'b1;
          end
        end
        sts_pkg::ModeSymbol: begin
          if (sts_pkg::is_ident(byte_i)) begin
            kw_d = sts_pkg::kw_update(kw_q, cnt_q, byte_i);
            res[n[1:0]] = sts_pkg::mk_text(sts_pkg::TokSymbol, byte_i);
            n = n + 3'd1;
            cnt_d = sat_inc(cnt_q);
          end else begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::symbol_kind(kw_q, cnt_q), '0, cnt_q);
            n = n + 3'd1;
            rescan = 1'b1;
          end
        end
        sts_pkg::ModeHash: begin
          if ((byte_i == sts_pkg::ChLowT) || (byte_i == sts_pkg::ChLowF)) begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokBool,
                                          {30'd0, byte_i == sts_pkg::ChLowT}, '0);
            n = n + 3'd1;
            mode_d = sts_pkg::ModeIdle;
          end else if (byte_i == sts_pkg::ChBslash) begin
            mode_d = sts_pkg::ModeHashBs;
          end else begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokHash, '0, '0);
            n = n + 3'd1;
            rescan = 1'b1;
          end
        end
        sts_pkg::ModeHashBs: begin
          if (byte_i == sts_pkg::ChNul) begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokHash, '0, '0);
            n = n + 3'd1;
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokEnd, '0, '0);
            n = n + 3'd1;
            stop_d = 1'b1;
            mode_d = sts_pkg::ModeIdle;
          end else begin
            res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokChar, {23'd0, byte_i}, '0);
            n = n + 3'd1;
            mode_d = sts_pkg::ModeIdle;
          end
        end
        default: rescan = 1'b1;
      endcase

      // byte that starts a new token
      if (rescan) begin
        mode_d = sts_pkg::ModeIdle;
        priority if ((byte_i == sts_pkg::ChSpace) || (byte_i == sts_pkg::ChTab) ||
                     (byte_i == sts_pkg::ChCr) || (byte_i == sts_pkg::ChLf)) begin
        end else if (byte_i == sts_pkg::ChLparen) begin
          res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokOpen, '0, '0);
          n = n + 3'd1;
        end else if (byte_i == sts_pkg::ChRparen) begin
          res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokClose, '0, '0);
          n = n + 3'd1;
        end else if (byte_i == sts_pkg::ChApos) begin
          res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokQuote, '0, '0);
          n = n + 3'd1;
        end else if (byte_i == sts_pkg::ChDot) begin
          res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokPeriod, '0, '0);
          n = n + 3'd1;
        end else if (byte_i == sts_pkg::ChDquote) begin
          mode_d = sts_pkg::ModeString;
          cnt_d  = '0;
        end else if (byte_i == sts_pkg::ChHash) begin
          mode_d = sts_pkg::ModeHash;
        end else if (byte_i == sts_pkg::ChSemi) begin
          mode_d = sts_pkg::ModeComment;
        end else if (sts_pkg::is_digit(byte_i)) begin
          mode_d = sts_pkg::ModeNumber;
          acc_d  = {23'd0, digit};
        end else if (sts_pkg::is_ident(byte_i)) begin
          mode_d = sts_pkg::ModeSymbol;
          kw_d   = sts_pkg::kw_update('1, '0, byte_i);
          cnt_d  = sts_pkg::LengthBits'(1);
          res[n[1:0]] = sts_pkg::mk_text(sts_pkg::TokSymbol, byte_i);
          n = n + 3'd1;
        end else begin
          res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokEnd, '0, '0);
          n = n + 3'd1;
          stop_d = 1'b1;
        end
      end

      // close of the text: flush what is pending, then the end token
      if (fin_i) begin
        if (!stop_d) begin
          unique case (mode_d)
            sts_pkg::ModeNumber: begin
              res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokNumber, acc_d, '0);
              n = n + 3'd1;
            end
            sts_pkg::ModeSymbol: begin
              res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::symbol_kind(kw_d, cnt_d), '0, cnt_d);
              n = n + 3'd1;
            end
            sts_pkg::ModeString: begin
              res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokString, '0, cnt_d);
              n = n + 3'd1;
            end
            sts_pkg::ModeHash, sts_pkg::ModeHashBs: begin
              res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokHash, '0, '0);
              n = n + 3'd1;
            end
            default: ;
          endcase
          res[n[1:0]] = sts_pkg::mk_rec(sts_pkg::TokEnd, '0, '0);
          n = n + 3'd1;
        end
        mode_d = sts_pkg::ModeIdle;
        acc_d  = '0;
        cnt_d  = '0;
        kw_d   = '1;
        stop_d = 1'b0;
      end
    end

    if (n != 3'd0) res[2'(n - 3'd1)].last_of_run = 1'b1;
  end

  assign batch_o.res   = res;
  assign batch_o.count = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sts_pkg::ModeIdle;
      acc_q  <= '0;
      cnt_q  <= '0;
      kw_q   <= '1;
      stop_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      kw_q   <= kw_d;
      stop_q <= stop_d;
    end
  end

endmodule

/* rtl/sts_result_queue.sv */
// result queue: takes up to four results a cycle, hands out one
module sts_result_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sts_pkg::sts_batch_t batch_i,
  input  logic                pop_i,
  output logic                room_o,
  output logic                valid_o,
  output sts_pkg::sts_result_t head_o
);

  sts_pkg::sts_result_t [sts_pkg::QDepth-1:0] entries_q;
  logic [sts_pkg::QPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [sts_pkg::QPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [sts_pkg::QCntBits-1:0] count_q, count_d;
  logic [2:0]                   n_push;
  logic                         do_pop;

  assign n_push  = push_i ? batch_i.count : 3'd0;
  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign head_o  = entries_q[rd_ptr_q];
  // room for a worst-case burst from one byte
  assign room_o  = (count_q <= sts_pkg::QCntBits'(sts_pkg::QDepth - sts_pkg::MaxResults));

  assign wr_ptr_d = wr_ptr_q + sts_pkg::QPtrBits'(n_push);
  assign rd_ptr_d = rd_ptr_q + sts_pkg::QPtrBits'(do_pop);
  assign count_d  = count_q + sts_pkg::QCntBits'(n_push) - sts_pkg::QCntBits'(do_pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < sts_pkg::MaxResults; i++) begin
      if (3'(i) < n_push) begin
        entries_q[wr_ptr_q + sts_pkg::QPtrBits'(i)] <= batch_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/scheme_token_scanner_top.sv */
// top level of the scheme token scanner
// Byte-serial Scheme lexer: one source byte per input transaction (tlast marks the
// final byte of a text), one result per output transaction. Each accepted byte has
// its results (none to four) written into an eight-entry result queue at the next
// clock edge, so the first result of a byte can appear the cycle after it was taken.
// Input is taken every cycle while the queue holds four results or fewer; the output
// drains one result per cycle while the receiver is ready, so bytes that give two to
// four results (a token closed by the next byte, the final byte, or both) hold the
// input back until the queue has drained to that level. Throughput is therefore one
// byte per cycle on text where each byte gives at most one result, if the receiver is
// ready, and otherwise set by the output port. No clearing pass is needed after reset.
module scheme_token_scanner_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // final_byte
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [3:0] token_kind, [34:4] token_value,
                                        // [42:35] text_char, [58:43] text_length, rest zero
  output logic        m_axis_tuser_o,   // result_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  logic                 in_accept;
  logic                 room;
  sts_pkg::sts_batch_t  batch;
  sts_pkg::sts_result_t head;

  // a byte is taken only when the queue can absorb its whole burst
  assign s_axis_tready_o = room;
  assign in_accept       = s_axis_tvalid_i && room;

  // scanner: state registers and the per-byte token logic
  sts_scanner u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata_i),
    .fin_i    (s_axis_tlast_i),
    .batch_o  (batch)
  );

  // results wait here, decoupling the byte side from the result side
  sts_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .batch_i (batch),
    .pop_i   (m_axis_tready_i),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head)
  );

  // pack the head result onto the output channel
  assign m_axis_tdata_o = {5'd0, head.text_length, head.text_char, head.token_value,
                           head.token_kind};
  assign m_axis_tuser_o = head.result_kind;
  assign m_axis_tlast_o = head.last_of_run;

endmodule

/* rtl/sts_checker.sv */
// port-level checks of the scanner, bound to the top level
`include "scheme_token_scanner_top_assert.svh"

module sts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // a result offered and not taken is still offered
  `STS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // text transactions carry only string or symbol kinds, no value and no length
  `STS_ASSERT(a_text_kind, m_axis_tvalid_o && m_axis_tuser_o,
    ((m_axis_tdata_o[3:0] == sts_pkg::TokString) || (m_axis_tdata_o[3:0] == sts_pkg::TokSymbol)) &&
    (m_axis_tdata_o[34:4] == 31'd0) && (m_axis_tdata_o[58:43] == 16'd0))

  // the end token is always the final result of its byte, with all other fields zero
  `STS_ASSERT(a_end_last, m_axis_tvalid_o && !m_axis_tuser_o && (m_axis_tdata_o[3:0] == sts_pkg::TokEnd),
    m_axis_tlast_o && (m_axis_tdata_o[63:4] == 60'd0))

  // a token record never carries a text character, and its padding is zero
  `STS_ASSERT(a_rec_nochar, m_axis_tvalid_o && !m_axis_tuser_o,
    (m_axis_tdata_o[42:35] == 8'd0) && (m_axis_tdata_o[63:59] == 5'd0))

endmodule

bind scheme_token_scanner_top sts_checker u_sts_checker (.*);

/* sim/scheme_token_scanner_top_test.sv */
// self-checking testbench of the scheme token scanner top level
module scheme_token_scanner_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // clock, reset and the signals towards the block
  // ---------------------------------------------------------------------------
  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_vld  = 1'b0;
  logic [7:0]  s_data = 8'd0;
  logic        s_last = 1'b0;
  logic        s_rdy;

  logic        m_vld;
  logic        m_rdy  = 1'b0;
  logic [63:0] m_data;
  logic        m_user;
  logic        m_last;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  scheme_token_scanner_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_vld),
    .s_axis_tready_o (s_rdy),
    .s_axis_tdata_i  (s_data),   // [7:0] text_byte
    .s_axis_tlast_i  (s_last),   // final_byte
    .m_axis_tvalid_o (m_vld),
    .m_axis_tready_i (m_rdy),
    .m_axis_tdata_o  (m_data),   // [3:0] token_kind, [34:4] token_value,
                                 // [42:35] text_char, [58:43] text_length
    .m_axis_tuser_o  (m_user),   // result_kind
    .m_axis_tlast_o  (m_last)    // last_of_run
  );

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } src_byte_t;

  src_byte_t            byte_queue[$];        // source bytes waiting to be driven
  sts_pkg::sts_result_t expected_results[$];  // results still owed by the block
  sts_pkg::sts_result_t run_q[$];             // results caused by the byte being scanned
  logic [7:0]           text_buf[$];          // text under construction

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors        = 0;
  int unsigned bytes_taken   = 0;
  int unsigned texts_taken   = 0;
  int unsigned results_seen  = 0;
  int unsigned random_bytes  = 0;

  src_byte_t            next_byte;
  sts_pkg::sts_result_t want;

  // identifier characters: letters and extras first, then hash, then digits
  string name_pool =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ!@$%^&*_-=+/?<>#0123456789";

  // ---------------------------------------------------------------------------
  // scanner prediction: own copy of the lexer state
  // ---------------------------------------------------------------------------
  sts_pkg::sts_mode_e             scan_state = sts_pkg::ModeIdle;
  logic [30:0]                    number_sum = '0;
  logic [sts_pkg::LengthBits-1:0] text_len   = '0;
  logic [sts_pkg::NumKw-1:0]      kw_alive   = '1;
  logic                           halted     = 1'b0;

  function automatic string kw_spelling(input int k);
    case (k)
      0:       return "define";
      1:       return "lambda";
      2:       return "if";
      3:       return "define-syntax";
      default: return "syntax-rules";
    endcase
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= sts_pkg::ChZero) && (c <= sts_pkg::ChNine);
  endfunction

  function automatic logic name_char(input logic [7:0] c);
    case (c)
      "!", "@", "#", "$", "%", "^", "&", "*",
      "_", "-", "=", "+", "/", "?", "<", ">": return 1'b1;
      default: return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
                      digit_char(c);
    endcase
  endfunction

  // at most four results per byte, the rest would be dropped
  task automatic emit_rec(input logic [3:0] kind, input logic [30:0] value,
                          input logic [sts_pkg::LengthBits-1:0] len);
    sts_pkg::sts_result_t r;
    r.result_kind = sts_pkg::RkRecord;
    r.token_kind  = kind;
    r.token_value = value;
    r.text_char   = 8'd0;
    r.text_length = len;
    r.last_of_run = 1'b0;
    if (run_q.size() < sts_pkg::MaxResults) run_q.push_back(r);
  endtask

  task automatic emit_text(input logic [3:0] kind, input logic [7:0] ch);
    sts_pkg::sts_result_t r;
    r.result_kind = sts_pkg::RkText;
    r.token_kind  = kind;
    r.token_value = 31'd0;
    r.text_char   = ch;
    r.text_length = '0;
    r.last_of_run = 1'b0;
    if (run_q.size() < sts_pkg::MaxResults) run_q.push_back(r);
  endtask

  task automatic reset_scanner();
    scan_state = sts_pkg::ModeIdle;
    number_sum = '0;
    text_len   = '0;
    kw_alive   = '1;
    halted     = 1'b0;
  endtask

  // early end of the token list, everything up to the final byte is ignored
  task automatic stop_text();
    emit_rec(sts_pkg::TokEnd, 31'd0, '0);
    halted     = 1'b1;
    scan_state = sts_pkg::ModeIdle;
  endtask

  // length saturates at all ones
  task automatic bump_count();
    if (text_len != '1) text_len = text_len + 1'b1;
  endtask

  task automatic add_symbol_char(input logic [7:0] b);
    int    p;
    string w;
    p = int'(text_len);
    for (int k = 0; k < sts_pkg::NumKw; k++) begin
      w = kw_spelling(k);
      if (p >= w.len() || w[p] != b) kw_alive[k] = 1'b0;
    end
    emit_text(sts_pkg::TokSymbol, b);
    bump_count();
  endtask

  task automatic close_symbol();
    logic [3:0] kind;
    string      w;
    kind = sts_pkg::TokSymbol;
    for (int k = 0; k < sts_pkg::NumKw; k++) begin
      w = kw_spelling(k);
      if (kw_alive[k] && int'(text_len) == w.len()) kind = sts_pkg::TokKwFirst + 4'(k);
    end
    emit_rec(kind, 31'd0, text_len);
  endtask

  // byte seen between tokens
  task automatic scan_fresh(input logic [7:0] b);
    scan_state = sts_pkg::ModeIdle;
    if (b == sts_pkg::ChSpace || b == sts_pkg::ChTab || b == sts_pkg::ChCr ||
        b == sts_pkg::ChLf) begin
    end else if (b == sts_pkg::ChLparen) begin
      emit_rec(sts_pkg::TokOpen, 31'd0, '0);
    end else if (b == sts_pkg::ChRparen) begin
      emit_rec(sts_pkg::TokClose, 31'd0, '0);
    end else if (b == sts_pkg::ChApos) begin
      emit_rec(sts_pkg::TokQuote, 31'd0, '0);
    end else if (b == sts_pkg::ChDot) begin
      emit_rec(sts_pkg::TokPeriod, 31'd0, '0);
    end else if (b == sts_pkg::ChDquote) begin
      scan_state = sts_pkg::ModeString;
      text_len   = '0;
    end else if (b == sts_pkg::ChHash) begin
      scan_state = sts_pkg::ModeHash;
    end else if (b == sts_pkg::ChSemi) begin
      scan_state = sts_pkg::ModeComment;
    end else if (digit_char(b)) begin
      scan_state = sts_pkg::ModeNumber;
      number_sum = 31'(b - sts_pkg::ChZero);
    end else if (name_char(b)) begin
      scan_state = sts_pkg::ModeSymbol;
      text_len   = '0;
      kw_alive   = '1;
      add_symbol_char(b);
    end else begin
      stop_text();
    end
  endtask

  // works out every result that one accepted byte causes
  task automatic predict_tokens(input logic [7:0] b, input logic fin);
    logic [63:0]          grown;
    sts_pkg::sts_result_t tail;
    run_q.delete();
    if (halted) begin
      if (fin) reset_scanner();
    end else begin
      case (scan_state)
        sts_pkg::ModeComment: begin
          if (b == sts_pkg::ChLf) scan_state = sts_pkg::ModeIdle;
          else if (b == sts_pkg::ChNul) stop_text();
        end
        sts_pkg::ModeString: begin
          if (b == sts_pkg::ChDquote) begin
            emit_rec(sts_pkg::TokString, 31'd0, text_len);
            scan_state = sts_pkg::ModeIdle;
          end else if (b == sts_pkg::ChNul) begin
            emit_rec(sts_pkg::TokString, 31'd0, text_len);
            stop_text();
          end else begin
            emit_text(sts_pkg::TokString, b);
            bump_count();
          end
        end
        sts_pkg::ModeNumber: begin
          if (digit_char(b)) begin
            grown = 64'(number_sum) * 64'd10 + 64'(b - sts_pkg::ChZero);
            number_sum = (grown > 64'(sts_pkg::NumMax)) ? sts_pkg::NumMax : grown[30:0];
          end else begin
            emit_rec(sts_pkg::TokNumber, number_sum, '0);
            scan_fresh(b);
          end
        end
        sts_pkg::ModeSymbol: begin
          if (name_char(b)) begin
            add_symbol_char(b);
          end else begin
            close_symbol();
            scan_fresh(b);
          end
        end
        sts_pkg::ModeHash: begin
          if (b == sts_pkg::ChLowT || b == sts_pkg::ChLowF) begin
            emit_rec(sts_pkg::TokBool, {30'd0, b == sts_pkg::ChLowT}, '0);
            scan_state = sts_pkg::ModeIdle;
          end else if (b == sts_pkg::ChBslash) begin
            scan_state = sts_pkg::ModeHashBs;
          end else begin
            emit_rec(sts_pkg::TokHash, 31'd0, '0);
            scan_fresh(b);
          end
        end
        sts_pkg::ModeHashBs: begin
          if (b == sts_pkg::ChNul) begin
            emit_rec(sts_pkg::TokHash, 31'd0, '0);
            stop_text();
          end else begin
            emit_rec(sts_pkg::TokChar, {23'd0, b}, '0);
            scan_state = sts_pkg::ModeIdle;
          end
        end
        default: scan_fresh(b);
      endcase

      // close of the text: flush the pending token, then the end token
      if (fin) begin
        if (!halted) begin
          case (scan_state)
            sts_pkg::ModeNumber: emit_rec(sts_pkg::TokNumber, number_sum, '0);
            sts_pkg::ModeSymbol: close_symbol();
            sts_pkg::ModeString: emit_rec(sts_pkg::TokString, 31'd0, text_len);
            sts_pkg::ModeHash, sts_pkg::ModeHashBs:
              emit_rec(sts_pkg::TokHash, 31'd0, '0);
            default: ;
          endcase
          emit_rec(sts_pkg::TokEnd, 31'd0, '0);
        end
        reset_scanner();
      end
    end

    if (run_q.size() > 0) begin
      tail = run_q.pop_back();
      tail.last_of_run = 1'b1;
      run_q.push_back(tail);
    end
    while (run_q.size() > 0) expected_results.push_back(run_q.pop_front());
  endtask

  // ---------------------------------------------------------------------------
  // driver: one byte transaction at a time from byte_queue
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld  <= 1'b0;
      s_data <= 8'd0;
      s_last <= 1'b0;
    end else begin
      if (s_vld && s_rdy) begin
        predict_tokens(s_data, s_last);
        bytes_taken++;
        if (s_last) texts_taken++;
      end
      // a new byte may be offered once the current one is gone
      if (!s_vld || s_rdy) begin
        if (byte_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_byte = byte_queue.pop_front();
          s_vld  <= 1'b1;
          s_data <= next_byte.ch;
          s_last <= next_byte.fin;
        end else begin
          s_vld <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_rdy <= 1'b0;
    end else begin
      if (m_vld && m_rdy) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, actual %0h/%0h",
                   $time, m_user, m_data);
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 64'(want.result_kind), 64'(m_user));
          check_field("token_kind",  64'(want.token_kind),  64'(m_data[3:0]));
          check_field("token_value", 64'(want.token_value), 64'(m_data[34:4]));
          check_field("text_char",   64'(want.text_char),   64'(m_data[42:35]));
          check_field("text_length", 64'(want.text_length), 64'(m_data[58:43]));
          check_field("padding",     64'd0,                 64'(m_data[63:59]));
          check_field("last_of_run", 64'(want.last_of_run), 64'(m_last));
        end
      end
      m_rdy <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] c, input logic fin);
    src_byte_t it;
    it.ch  = c;
    it.fin = fin;
    byte_queue.push_back(it);
  endtask

  task automatic push_char(input logic [7:0] c);
    text_buf.push_back(c);
  endtask

  task automatic push_word(input string w);
    for (int i = 0; i < w.len(); i++) push_char(w[i]);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3, 0))
      0:       return sts_pkg::ChSpace;
      1:       return sts_pkg::ChTab;
      2:       return sts_pkg::ChCr;
      default: return sts_pkg::ChLf;
    endcase
  endfunction

  // any byte that keeps a string open
  function automatic logic [7:0] string_char();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    while (c == sts_pkg::ChDquote) c = 8'($urandom_range(255, 1));
    return c;
  endfunction

  // lead characters never start a number or a hash
  function automatic logic [7:0] ident_char(input logic lead);
    return name_pool[lead ? $urandom_range(66, 0) : $urandom_range(name_pool.len() - 1, 0)];
  endfunction

  // one text of mostly well-formed tokens, with the odd broken sequence
  task automatic make_text(input int n_tok);
    int   pick;
    int   len;
    logic noisy;
    text_buf.delete();
    noisy = 1'b0;
    for (int i = 0; i < n_tok && !noisy; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        push_char(sts_pkg::ChLparen);
      end else if (pick < 16) begin
        push_char(sts_pkg::ChRparen);
      end else if (pick < 20) begin
        push_char(sts_pkg::ChApos);
      end else if (pick < 23) begin
        push_char(sts_pkg::ChDot);
      end else if (pick < 35) begin
        // string, now and then left open
        push_char(sts_pkg::ChDquote);
        len = $urandom_range(5, 0);
        repeat (len) push_char(string_char());
        if ($urandom_range(9, 0) != 0) push_char(sts_pkg::ChDquote);
      end else if (pick < 41) begin
        push_char(sts_pkg::ChHash);
        push_char($urandom_range(1, 0) ? sts_pkg::ChLowT : sts_pkg::ChLowF);
      end else if (pick < 47) begin
        push_char(sts_pkg::ChHash);
        push_char(sts_pkg::ChBslash);
        push_char(8'($urandom_range(255, 1)));
      end else if (pick < 50) begin
        push_char(sts_pkg::ChHash);
      end else if (pick < 63) begin
        // long runs drive the value into saturation
        len = ($urandom_range(4, 0) == 0) ? $urandom_range(12, 10) : $urandom_range(3, 1);
        repeat (len) push_char(sts_pkg::ChZero + 8'($urandom_range(9, 0)));
      end else if (pick < 80) begin
        pick = $urandom_range(9, 0);
        case (pick)
          0, 1, 2, 3, 4: push_word(kw_spelling(pick));
          5:             push_word("def");
          6:             push_word("iff");
          7:             push_word("syntax-rule");
          8:             push_word("lambdas");
          default: begin
            push_char(ident_char(1'b1));
            repeat ($urandom_range(5, 0)) push_char(ident_char(1'b0));
          end
        endcase
      end else if (pick < 85) begin
        push_char(sts_pkg::ChSemi);
        repeat ($urandom_range(4, 0)) push_char(8'($urandom_range(126, 32)));
        push_char(sts_pkg::ChLf);
      end else if (pick < 88) begin
        // arbitrary byte, usually an early end, then one trailing byte
        push_char(8'($urandom_range(255, 0)));
        push_char(8'($urandom_range(255, 0)));
        noisy = 1'b1;
      end else begin
        push_char(blank_char());
      end
      // tokens often butt against each other
      if (!noisy && $urandom_range(2, 0) != 0) push_char(blank_char());
    end
    // a dangling hash-backslash at the close of input
    if (!noisy && $urandom_range(7, 0) == 0) begin
      push_char(sts_pkg::ChHash);
      push_char(sts_pkg::ChBslash);
    end
    if (text_buf.size() == 0) push_char(sts_pkg::ChSpace);
    foreach (text_buf[j]) queue_byte(text_buf[j], j == text_buf.size() - 1);
    random_bytes += text_buf.size();
  endtask

  task automatic wait_sent();
    while (byte_queue.size() != 0 || s_vld) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase one: sender rarely idles, receiver stalls half the time
    send_idle_pct = 7;
    recv_idle_pct = 51;

    // directed: every token kind but the keywords, a number closed by a bracket,
    // hash before another byte, char 255, a symbol cut by an unknown byte and
    // the ignored bytes up to the final one
    queue_byte(sts_pkg::ChLparen, 1'b0);
    queue_byte("1", 1'b0);
    queue_byte("2", 1'b0);
    queue_byte(sts_pkg::ChRparen, 1'b0);
    queue_byte(sts_pkg::ChHash, 1'b0);
    queue_byte(sts_pkg::ChLparen, 1'b0);
    queue_byte(sts_pkg::ChHash, 1'b0);
    queue_byte(sts_pkg::ChLowT, 1'b0);
    queue_byte(sts_pkg::ChHash, 1'b0);
    queue_byte(sts_pkg::ChBslash, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(sts_pkg::ChApos, 1'b0);
    queue_byte(sts_pkg::ChDot, 1'b0);
    queue_byte(sts_pkg::ChDquote, 1'b0);
    queue_byte("a", 1'b0);
    queue_byte(sts_pkg::ChDquote, 1'b0);
    queue_byte("x", 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte("z", 1'b1);
    // nul inside a comment
    queue_byte(sts_pkg::ChSemi, 1'b0);
    queue_byte(sts_pkg::ChNul, 1'b1);
    // nul inside a string
    queue_byte(sts_pkg::ChDquote, 1'b0);
    queue_byte(sts_pkg::ChNul, 1'b1);
    // hash-backslash followed by nul
    queue_byte(sts_pkg::ChHash, 1'b0);
    queue_byte(sts_pkg::ChBslash, 1'b0);
    queue_byte(sts_pkg::ChNul, 1'b1);

    while (random_bytes < 30) make_text($urandom_range(8, 1));
    wait_sent();

    // phase two: roles swapped
    send_idle_pct = 51;
    recv_idle_pct = 7;
    while (random_bytes < 65) make_text($urandom_range(8, 1));
    wait_sent();

    // phase three: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (random_bytes < 100) make_text($urandom_range(8, 1));
    wait_sent();

    // drain, then keep watching for stray results
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("scanned %0d bytes in %0d texts, %0d result transactions checked",
             bytes_taken, texts_taken, results_seen);
    $display("both sides stalled in turn, then full rate, over every token kind");
    if (errors == 0) begin
      $display("** scheme_token_scanner_top: PASSED **");
    end else begin
      $display("** scheme_token_scanner_top: FAILED **");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("** scheme_token_scanner_top: FAILED **");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/sts_pkg.sv
rtl/sts_scanner.sv
rtl/sts_result_queue.sv
rtl/scheme_token_scanner_top.sv
rtl/sts_checker.sv
sim/scheme_token_scanner_top_test.sv
